@@ rtl/core/fbr_pkg.sv @@
// Shared types and constants for the FNV-1a bucket router.
// Used by fbr_front, fbr_queue, fbr_back and fnv1a_bucket_router.
package fbr_pkg;

    localparam logic [31:0] FNV_BASIS       = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME       = 32'd16777619;
    localparam logic [7:0]  KEY_SEP         = 8'h1F;

    // bucket_count register
    localparam int          CNT_W           = 17;
    localparam logic [CNT_W-1:0] DEFAULT_BUCKETS = 17'd64;

    localparam int          IDX_W           = 16;
    localparam int          QUEUE_DEPTH     = 2;

    // finished key handed from front to back
    typedef struct packed {
        logic [31:0] hash;
        logic        too_long;
    } key_result_t;

endpackage

@@ rtl/core/fnv1a_bucket_router.sv @@
// Top level of the FNV-1a bucket router: config register, front, queue, back.
// Depends on fbr_pkg, fbr_front, fbr_queue, fbr_back.
//
//  channel   direction  fields (low bit first)
//  s_*       in         tdata: key_byte[7:0]; tuser: byte_present; tlast: key_end
//  m_*       out        tdata: bucket_index[15:0], prefix_hash[47:16]; tuser: key_too_long
//  cfg_*     in         cfg_data: bucket_count[16:0]
//
// Front takes one request per cycle while the queue has a free slot; a full queue stalls all.
// Each key then passes through the back end: a 32-step serial modulo, the load and the output.
// The queue holds two finished keys so the front keeps streaming during a modulo.
// aresetn is synchronous, active low; bucket_count resets to 64.
// m_tvalid holds with stable data until m_tready; a stalled output backs up the queue.
module fnv1a_bucket_router import fbr_pkg::*; #(
    parameter int MAX_BUCKETS   = 65536,
    parameter int MAX_KEY_BYTES = 512
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // key_byte
    input  logic              s_tuser,   // byte_present
    input  logic              s_tlast,   // key_end
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // bucket_index, prefix_hash
    output logic              m_tuser,   // key_too_long
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data   // bucket_count
);

    logic [CNT_W-1:0] bucket_count_reg;
    logic             in_fire;
    logic             push, pop, q_empty, q_full;
    key_result_t      push_data, pop_data;
    logic [IDX_W-1:0] out_index;
    logic [31:0]      out_hash;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= DEFAULT_BUCKETS;
        end else if (cfg_valid && cfg_ready) begin
            bucket_count_reg <= cfg_data;
        end
    end

    fbr_front #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_byte    (s_tdata),
        .in_present (s_tuser),
        .in_end     (s_tlast),
        .push       (push),
        .push_data  (push_data)
    );

    fbr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    fbr_back #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bucket_count (bucket_count_reg),
        .q_empty      (q_empty),
        .q_data       (pop_data),
        .q_pop        (pop),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_index      (out_index),
        .m_hash       (out_hash),
        .m_too_long   (m_tuser)
    );

    assign m_tdata = {out_hash, out_index};

endmodule

@@ rtl/core/fbr_front.sv @@
// Front end: folds prefix bytes into the FNV-1a hash, one request per cycle while
// in_fire. At key end pushes a key_result_t into the queue. Depends on fbr_pkg.
module fbr_front import fbr_pkg::*; #(
    parameter int MAX_KEY_BYTES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [7:0]  in_byte,
    input  logic        in_present,
    input  logic        in_end,
    output logic        push,
    output key_result_t push_data
);

    localparam int BC_W = $clog2(MAX_KEY_BYTES + 2);

    logic [31:0]     hash_reg, hash_next;
    logic            sep_reg, sep_next;
    logic [BC_W-1:0] count_reg, count_next;

    logic [31:0] mixed;
    logic [31:0] folded;

    assign mixed  = hash_reg ^ {24'd0, in_byte};
    assign folded = 32'(mixed * FNV_PRIME);

    always_comb begin
        hash_next  = hash_reg;
        sep_next   = sep_reg;
        count_next = count_reg;
        if (in_present) begin
            if (count_reg <= BC_W'(MAX_KEY_BYTES)) begin
                count_next = count_reg + 1'b1;
            end
            if (!sep_reg) begin
                if (in_byte == KEY_SEP) begin
                    sep_next = 1'b1;
                end else begin
                    hash_next = folded;
                end
            end
        end
    end

    assign push               = in_fire && in_end;
    assign push_data.hash     = hash_next;
    assign push_data.too_long = count_next > BC_W'(MAX_KEY_BYTES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg  <= FNV_BASIS;
            sep_reg   <= 1'b0;
            count_reg <= '0;
        end else if (in_fire) begin
            if (in_end) begin
                hash_reg  <= FNV_BASIS;
                sep_reg   <= 1'b0;
                count_reg <= '0;
            end else begin
                hash_reg  <= hash_next;
                sep_reg   <= sep_next;
                count_reg <= count_next;
            end
        end
    end

    // count saturates one past the limit
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= BC_W'(MAX_KEY_BYTES + 1))
        else $error("byte count past saturation");

    // hash frozen once the separator was seen
    a_hash_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (sep_reg && in_fire && !in_end) |=> $stable(hash_reg))
        else $error("hash changed after separator");

endmodule

@@ rtl/core/fbr_queue.sv @@
// Short FIFO of finished keys between front and back end.
// Depends on fbr_pkg for key_result_t and QUEUE_DEPTH.
module fbr_queue import fbr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  key_result_t push_data,
    input  logic        pop,
    output key_result_t pop_data,
    output logic        empty,
    output logic        full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    key_result_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [OCC_W-1:0]  occ_reg;

    assign empty    = occ_reg == '0;
    assign full     = occ_reg == OCC_W'(QUEUE_DEPTH);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                occ_reg <= occ_reg + 1'b1;
            end else if (pop && !push) begin
                occ_reg <= occ_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

@@ rtl/core/fbr_back.sv @@
// Back end: bit-serial modulo of the prefix hash by the bucket count,
// plus the result output register. Depends on fbr_pkg.
module fbr_back import fbr_pkg::*; #(
    parameter int MAX_BUCKETS = 65536
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CNT_W-1:0]  bucket_count,
    input  logic              q_empty,
    input  key_result_t       q_data,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [IDX_W-1:0]  m_index,
    output logic [31:0]       m_hash,
    output logic              m_too_long
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]       state_reg;
    logic [4:0]       step_reg;
    logic [31:0]      dvd_reg;
    logic [31:0]      hash_reg;
    logic             long_reg;
    logic [CNT_W-1:0] div_reg;
    logic [CNT_W-1:0] rem_reg;

    logic             out_valid_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic [31:0]      out_hash_reg;
    logic             out_long_reg;

    logic [CNT_W-1:0] base_cnt, eff_cnt;
    logic [CNT_W:0]   trial;
    logic [CNT_W-1:0] rem_next;
    logic             load_out;

    // zero means default; above the directory size clamps
    always_comb begin
        base_cnt = (bucket_count == '0) ? DEFAULT_BUCKETS : bucket_count;
        if (32'(base_cnt) > 32'(MAX_BUCKETS)) begin
            eff_cnt = CNT_W'(MAX_BUCKETS);
        end else begin
            eff_cnt = base_cnt;
        end
    end

    // one restoring step per cycle, quotient bits dropped
    always_comb begin
        trial = {rem_reg, dvd_reg[31]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = CNT_W'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign load_out = (state_reg == ST_HOLD) && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        state_reg <= ST_DIV;
                        step_reg  <= 5'd31;
                    end
                end
                ST_DIV: begin
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            dvd_reg  <= q_data.hash;
            hash_reg <= q_data.hash;
            long_reg <= q_data.too_long;
            div_reg  <= eff_cnt;
            rem_reg  <= '0;
        end else if (state_reg == ST_DIV) begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_index_reg <= rem_reg[IDX_W-1:0];
            out_hash_reg  <= hash_reg;
            out_long_reg  <= long_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_index    = out_index_reg;
    assign m_hash     = out_hash_reg;
    assign m_too_long = out_long_reg;

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> (rem_reg < div_reg))
        else $error("remainder not below divisor");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (div_reg != '0))
        else $error("zero divisor in modulo unit");

endmodule

@@ tb/sv/fnv1a_bucket_router_tb.sv @@
// Self-checking bench for fnv1a_bucket_router: prefix hash, bucket index and length flag.
// Needs fbr_pkg and the router RTL; stimulus, prediction and checks all live here.
`timescale 1ns / 1ps

module fnv1a_bucket_router_tb;
    import fbr_pkg::*;

    localparam int MAX_BUCKETS   = 65536;
    localparam int MAX_KEY_BYTES = 512;
    localparam int PHASE_ITEMS   = 105;
    localparam int TAIL_CYCLES   = 100;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int N_DIRECTED    = 21;
    localparam int N_PHASES      = 8;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [31:0]      hash;
        logic             too_long;
    } route_t;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       present;
        logic       last;
        logic       pinned;    // use the typed-in route instead of the predictor
        route_t     route;
    } stim_row_t;

    localparam route_t NO_ROUTE  = '0;
    // empty prefix at the reset bucket count of 64: basis 0x811C9DC5, low six bits = 5
    localparam route_t EMPTY_KEY = '{16'd5, FNV_BASIS, 1'b0};

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             s_tlast   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [47:0]      m_tdata;
    logic             m_tuser;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data  = '0;

    // typed-in expectation travels with the request
    logic             pin_en    = 1'b0;
    route_t           pin_route = '0;

    // predictor state
    logic [31:0]      run_hash;
    logic             sep_seen;
    int               key_len;
    logic [CNT_W-1:0] bucket_cnt;
    route_t           route_q[$];

    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               phase_items;
    int               req_count   = 0;
    int               keys_routed = 0;
    int               over_long   = 0;
    int               err_count   = 0;
    int unsigned      cycles      = 0;

    stim_row_t dir_rows [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_KEY},  // empty key
        '{8'hAA, 1'b0, 1'b0, 1'b0, NO_ROUTE},   // no byte, no end
        '{8'h1F, 1'b1, 1'b1, 1'b1, EMPTY_KEY},  // lone separator with end
        '{8'h00, 1'b1, 1'b1, 1'b0, NO_ROUTE},   // zero byte is hashed
        '{8'hFF, 1'b1, 1'b1, 1'b0, NO_ROUTE},
        '{8'h1F, 1'b1, 1'b0, 1'b0, NO_ROUTE},
        '{8'h41, 1'b1, 1'b0, 1'b0, NO_ROUTE},
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_KEY},  // everything after the separator
        '{8'h61, 1'b1, 1'b0, 1'b0, NO_ROUTE},
        '{8'h62, 1'b1, 1'b0, 1'b0, NO_ROUTE},
        '{8'h55, 1'b0, 1'b0, 1'b0, NO_ROUTE},   // idle request mid-key
        '{8'h1F, 1'b1, 1'b0, 1'b0, NO_ROUTE},
        '{8'h63, 1'b1, 1'b0, 1'b0, NO_ROUTE},
        '{8'h1F, 1'b1, 1'b0, 1'b0, NO_ROUTE},   // second separator
        '{8'h64, 1'b1, 1'b1, 1'b0, NO_ROUTE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_ROUTE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_ROUTE},
        '{8'hFF, 1'b1, 1'b1, 1'b0, NO_ROUTE},
        '{8'h80, 1'b1, 1'b0, 1'b0, NO_ROUTE},
        '{8'h7F, 1'b1, 1'b1, 1'b0, NO_ROUTE},
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_KEY}
    };

    // extremes, clamp and zero-default cases; slot 5 is drawn at run time
    logic [CNT_W-1:0] cnt_plan [N_PHASES] = '{
        17'd1, 17'd65536, 17'd131071, 17'd0, 17'd2, 17'd64, 17'd65537, 17'd3
    };

    fnv1a_bucket_router #(
        .MAX_BUCKETS   (MAX_BUCKETS),
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [31:0] fnv_fold(logic [31:0] h, logic [7:0] b);
        return (h ^ {24'd0, b}) * FNV_PRIME;
    endfunction

    function automatic logic [IDX_W-1:0] bucket_of(logic [31:0] h, logic [CNT_W-1:0] cnt);
        logic [31:0] n;
        n = {{(32-CNT_W){1'b0}}, cnt};
        if (n == 0)
            n = {{(32-CNT_W){1'b0}}, DEFAULT_BUCKETS};
        if (n > MAX_BUCKETS)
            n = MAX_BUCKETS;
        return IDX_W'(h % n);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return KEY_SEP;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // predictor and scoreboard
    always @(posedge aclk) begin
        route_t want;
        route_t got;
        if (!aresetn) begin
            run_hash   = FNV_BASIS;
            sep_seen   = 1'b0;
            key_len    = 0;
            bucket_cnt = DEFAULT_BUCKETS;
        end else begin
            if (cfg_valid && cfg_ready)
                bucket_cnt = cfg_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser) begin
                    if (key_len <= MAX_KEY_BYTES)
                        key_len++;
                    if (!sep_seen) begin
                        if (s_tdata == KEY_SEP)
                            sep_seen = 1'b1;
                        else
                            run_hash = fnv_fold(run_hash, s_tdata);
                    end
                end
                if (s_tlast) begin
                    want = pin_en ? pin_route
                                  : '{bucket_of(run_hash, bucket_cnt), run_hash,
                                      key_len > MAX_KEY_BYTES};
                    route_q.push_back(want);
                    run_hash = FNV_BASIS;
                    sep_seen = 1'b0;
                    key_len  = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[15:0], m_tdata[47:16], m_tuser};
                if (route_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected route, expected none, actual idx %0h hash %0h long %0b",
                             $time, got.idx, got.hash, got.too_long);
                end else begin
                    want = route_q.pop_front();
                    cmp_field("bucket_index", 32'(want.idx), 32'(got.idx));
                    cmp_field("prefix_hash", want.hash, got.hash);
                    cmp_field("key_too_long", 32'(want.too_long), 32'(got.too_long));
                    keys_routed++;
                    if (want.too_long)
                        over_long++;
                end
            end
        end
    end

    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d routes outstanding", $time, route_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [7:0] b, logic present, logic last, logic pin, route_t pr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= b;
        s_tuser   <= present;
        s_tlast   <= last;
        pin_en    <= pin;
        pin_route <= pr;
        do @(posedge aclk); while (!s_tready);
        if (present || last) begin
            phase_items++;
            req_count++;
        end
    endtask

    // n key bytes, maybe one forced separator, end fused with the last byte or on its own
    task automatic send_key(int n);
        int  sep_at;
        bit  fuse;
        sep_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, n)) : -1;
        fuse   = (n > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_ROUTE);
            send_item((i == sep_at) ? KEY_SEP : pick_byte(), 1'b1,
                      fuse && (i == n - 1), 1'b0, NO_ROUTE);
        end
        if (!fuse)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_ROUTE);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (route_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic load_buckets(logic [CNT_W-1:0] cnt);
        cfg_valid <= 1'b1;
        cfg_data  <= cnt;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        phase_items = 0;
        foreach (dir_rows[i])
            send_item(dir_rows[i].key_byte, dir_rows[i].present, dir_rows[i].last,
                      dir_rows[i].pinned, dir_rows[i].route);
        drain();

        cnt_plan[5] = CNT_W'($urandom_range(3, 65535));
        for (int ph = 0; ph < N_PHASES; ph++) begin
            load_buckets(cnt_plan[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            phase_items = 0;
            // length limit: one key just over, one exactly at
            if (ph == 1)
                send_key(MAX_KEY_BYTES + 1);
            if (ph == 6)
                send_key(MAX_KEY_BYTES);
            while (phase_items < PHASE_ITEMS)
                send_key(($urandom_range(0, 15) == 0) ? int'($urandom_range(11, 40))
                                                      : int'($urandom_range(0, 10)));
            drain();
        end

        if (route_q.size() != 0) begin
            err_count++;
            $display("%0t: %0d routes never arrived", $time, route_q.size());
        end
        $display("Routed %0d keys (%0d over-long) from %0d key requests", keys_routed,
                 over_long, req_count);
        $display("Bucket counts swept over %0d settings incl. 0, 1, 65536 and clamped values",
                 N_PHASES);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/fbr_pkg.sv
rtl/core/fbr_front.sv
rtl/core/fbr_queue.sv
rtl/core/fbr_back.sv
rtl/core/fnv1a_bucket_router.sv
tb/sv/fnv1a_bucket_router_tb.sv
